@@ rtl/i2cdac_pkg.sv @@
package i2cdac_pkg;

  localparam int CODE_BITS     = 12;
  localparam int PD_BITS       = 2;
  localparam int BUSY_BITS     = 16;
  localparam int PIN_BITS      = 3;
  localparam int BYTE_BITS     = 8;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;

  // Upper four bits of the seven-bit device address (0x60 to 0x67).
  localparam logic [3:0] DEV_ADDR_HI = 4'b1100;

  localparam logic [BUSY_BITS-1:0] BUSY_TICKS_RESET = 16'd1000;

  localparam logic [BYTE_BITS-1:0] GC_ADDR   = 8'h00;
  localparam logic [BYTE_BITS-1:0] GC_RESET  = 8'h06;
  localparam logic [BYTE_BITS-1:0] GC_WAKEUP = 8'h09;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    K_IDLE    = 3'd0,
    K_WRITE   = 3'd1,
    K_FAST    = 3'd2,
    K_REG_DAC = 3'd3,
    K_REG_EE  = 3'd4,
    K_READ    = 3'd5,
    K_GCALL   = 3'd6,
    K_IGNORE  = 3'd7
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ADDRESS_PINS = 1'b0,
    CFG_BUSY_TICKS   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [BYTE_BITS-1:0] bus_byte;
  } item_t;

  typedef struct packed {
    logic                 acknowledge;
    logic [BYTE_BITS-1:0] read_byte;
    logic [CODE_BITS-1:0] output_code;
    logic [PD_BITS-1:0]   power_down_mode;
    logic                 ready_res;
  } result_t;

  typedef struct packed {
    logic [PIN_BITS-1:0]  address_pins;
    logic [BUSY_BITS-1:0] busy_ticks;
  } cfg_t;

endpackage

@@ rtl/i2cdac_cfg.sv @@
module i2cdac_cfg (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [i2cdac_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [i2cdac_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output i2cdac_pkg::cfg_t                       cfg_o
);
  import i2cdac_pkg::*;

  logic [PIN_BITS-1:0]  pins_q, pins_d;
  logic [BUSY_BITS-1:0] ticks_q, ticks_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    pins_d  = pins_q;
    ticks_d = ticks_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ADDRESS_PINS: pins_d  = cfg_data_i[PIN_BITS-1:0];
        CFG_BUSY_TICKS:   ticks_d = cfg_data_i[BUSY_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pins_q  <= '0;
      ticks_q <= BUSY_TICKS_RESET;
    end else begin
      pins_q  <= pins_d;
      ticks_q <= ticks_d;
    end
  end

  assign cfg_o.address_pins = pins_q;
  assign cfg_o.busy_ticks   = ticks_q;

endmodule

@@ rtl/i2cdac_core.sv @@
module i2cdac_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  i2cdac_pkg::item_t   item_i,
  input  i2cdac_pkg::cfg_t    cfg_i,
  output i2cdac_pkg::result_t res_o
);
  import i2cdac_pkg::*;

  localparam logic [2:0] IDX_STATUS  = 3'd0;
  localparam logic [2:0] IDX_FRAME1  = 3'd1;
  localparam logic [2:0] IDX_FRAME2  = 3'd2;
  localparam logic [2:0] IDX_EE_HIGH = 3'd3;
  localparam logic [2:0] IDX_LAST    = 3'd4;

  logic [CODE_BITS-1:0] dac_code_q, dac_code_d;
  logic [PD_BITS-1:0]   dac_pd_q, dac_pd_d;
  logic [CODE_BITS-1:0] stored_code_q, stored_code_d;
  logic [PD_BITS-1:0]   stored_pd_q, stored_pd_d;
  logic [BUSY_BITS-1:0] busy_q, busy_d;
  logic [2:0]           byte_idx_q, byte_idx_d;
  kind_e                kind_q, kind_d;
  logic [BYTE_BITS-1:0] held_q, held_d;
  logic [PD_BITS-1:0]   pending_pd_q, pending_pd_d;

  logic                 ack;
  logic [BYTE_BITS-1:0] rd;
  logic                 wr_req;
  logic                 wr_ee;
  logic [CODE_BITS-1:0] wr_code;
  logic [PD_BITS-1:0]   wr_pd;
  logic [BYTE_BITS-1:0] b;

  assign b = item_i.bus_byte;

  always_comb begin
    dac_code_d    = dac_code_q;
    dac_pd_d      = dac_pd_q;
    stored_code_d = stored_code_q;
    stored_pd_d   = stored_pd_q;
    busy_d        = busy_q;
    byte_idx_d    = byte_idx_q;
    kind_d        = kind_q;
    held_d        = held_q;
    pending_pd_d  = pending_pd_q;
    ack           = 1'b0;
    rd            = '0;
    wr_req        = 1'b0;
    wr_ee         = 1'b0;
    wr_code       = '0;
    wr_pd         = '0;

    case (item_i.cmd)
      CMD_START: begin
        byte_idx_d = '0;
        if (b[7:1] == {DEV_ADDR_HI, cfg_i.address_pins}) begin
          kind_d = b[0] ? K_READ : K_WRITE;
          ack    = 1'b1;
        end else if (b == GC_ADDR) begin
          kind_d = K_GCALL;
          ack    = 1'b1;
        end else begin
          kind_d = K_IGNORE;
        end
      end
      CMD_DATA: begin
        case (kind_q)
          K_READ: begin
            case (byte_idx_q)
              IDX_STATUS:  rd = {(busy_q == '0), 1'b1, 3'b000, dac_pd_q, 1'b0};
              IDX_FRAME1:  rd = dac_code_q[11:4];
              IDX_FRAME2:  rd = {dac_code_q[3:0], 4'b0000};
              IDX_EE_HIGH: rd = {1'b0, stored_pd_q, 1'b0, stored_code_q[11:8]};
              default:     rd = stored_code_q[7:0];
            endcase
            byte_idx_d = (byte_idx_q >= IDX_LAST) ? IDX_STATUS : byte_idx_q + 3'd1;
          end
          K_GCALL: begin
            if (b == GC_RESET) begin
              dac_code_d = stored_code_q;
              dac_pd_d   = stored_pd_q;
              ack        = 1'b1;
            end else if (b == GC_WAKEUP) begin
              dac_pd_d = '0;
              ack      = 1'b1;
            end
          end
          K_WRITE: begin
            if (b[7:6] == 2'b00) begin
              kind_d     = K_FAST;
              held_d     = b;
              byte_idx_d = IDX_FRAME1;
              ack        = 1'b1;
            end else if (b[7:6] == 2'b01) begin
              // Bit 5 picks DAC and EEPROM over the DAC alone.
              kind_d       = b[5] ? K_REG_EE : K_REG_DAC;
              pending_pd_d = b[2:1];
              byte_idx_d   = IDX_FRAME1;
              ack          = 1'b1;
            end else begin
              kind_d = K_IGNORE;
            end
          end
          K_FAST: begin
            wr_req     = 1'b1;
            wr_code    = {held_q[3:0], b};
            wr_pd      = held_q[5:4];
            kind_d     = K_WRITE;
            byte_idx_d = IDX_STATUS;
            ack        = 1'b1;
          end
          K_REG_DAC, K_REG_EE: begin
            if (byte_idx_q == IDX_FRAME1) begin
              held_d     = b;
              byte_idx_d = IDX_FRAME2;
            end else begin
              wr_req     = 1'b1;
              wr_ee      = (kind_q == K_REG_EE);
              wr_code    = {held_q, b[7:4]};
              wr_pd      = pending_pd_q;
              kind_d     = K_WRITE;
              byte_idx_d = IDX_STATUS;
            end
            ack = 1'b1;
          end
          default: ;
        endcase
      end
      CMD_STOP: begin
        kind_d     = K_IDLE;
        byte_idx_d = '0;
      end
      CMD_TICK: begin
        if (busy_q != '0) begin
          busy_d = busy_q - 16'd1;
        end
      end
      default: ;
    endcase

    // A completed write frame is dropped while the EEPROM is busy.
    if (wr_req && (busy_q == '0)) begin
      dac_code_d = wr_code;
      dac_pd_d   = wr_pd;
      if (wr_ee) begin
        stored_code_d = wr_code;
        stored_pd_d   = wr_pd;
        busy_d        = cfg_i.busy_ticks;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dac_code_q    <= '0;
      dac_pd_q      <= '0;
      stored_code_q <= '0;
      stored_pd_q   <= '0;
      busy_q        <= '0;
      byte_idx_q    <= '0;
      kind_q        <= K_IDLE;
      held_q        <= '0;
      pending_pd_q  <= '0;
    end else if (step_i) begin
      dac_code_q    <= dac_code_d;
      dac_pd_q      <= dac_pd_d;
      stored_code_q <= stored_code_d;
      stored_pd_q   <= stored_pd_d;
      busy_q        <= busy_d;
      byte_idx_q    <= byte_idx_d;
      kind_q        <= kind_d;
      held_q        <= held_d;
      pending_pd_q  <= pending_pd_d;
    end
  end

  assign res_o.acknowledge     = ack;
  assign res_o.read_byte       = rd;
  assign res_o.output_code     = dac_code_d;
  assign res_o.power_down_mode = dac_pd_d;
  assign res_o.ready_res       = (busy_d == '0);

endmodule

@@ rtl/i2c_dac_register_model_top.sv @@
// A bus event accepted into the input register passes through the decode logic into
// the output register once that register is empty or being taken.
// Throughput: one bus event per cycle unless the output side stalls; the input register,
// the decode logic and the output register form a two-stage pipeline with no feedback
// other than device state. Reset (asynchronous, active low) empties both stages, clears
// all device state, sets the address pins to zero and the EEPROM busy time to 1000 ticks.
module i2c_dac_register_model_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           cmd_i,
  input  logic [i2cdac_pkg::BYTE_BITS-1:0]     bus_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 acknowledge_o,
  output logic [i2cdac_pkg::BYTE_BITS-1:0]     read_byte_o,
  output logic [i2cdac_pkg::CODE_BITS-1:0]     output_code_o,
  output logic [i2cdac_pkg::PD_BITS-1:0]       power_down_mode_o,
  output logic                                 ready_res_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [i2cdac_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [i2cdac_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import i2cdac_pkg::*;

  // Stage one holds the accepted request; stage two holds its finished result.
  logic    s1_valid_q, s1_valid_d;
  item_t   s1_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;

  logic    out_take;
  logic    advance;
  logic    in_accept;
  cfg_t    cfg;
  result_t core_res;
  item_t   in_item;

  // The output register can be loaded when it is empty or is being taken now.
  assign out_take  = !out_valid_q || !out_stall_i;
  // A request in stage one is processed and leaves in the same cycle that
  // the output register has room, so device state updates once per request.
  assign advance   = s1_valid_q && out_take;
  assign in_stall_o = s1_valid_q && !out_take;
  assign in_accept = in_valid_i && !in_stall_o;

  assign in_item.cmd      = cmd_e'(cmd_i);
  assign in_item.bus_byte = bus_byte_i;

  i2cdac_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  i2cdac_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (core_res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers only load with their handshake and need no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item;
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign acknowledge_o     = out_res_q.acknowledge;
  assign read_byte_o       = out_res_q.read_byte;
  assign output_code_o     = out_res_q.output_code;
  assign power_down_mode_o = out_res_q.power_down_mode;
  assign ready_res_o       = out_res_q.ready_res;

endmodule

@@ rtl/i2cdac_chk.sv @@
module i2cdac_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic                                 acknowledge_o,
  input logic [i2cdac_pkg::BYTE_BITS-1:0]     read_byte_o,
  input logic [i2cdac_pkg::CODE_BITS-1:0]     output_code_o,
  input logic [i2cdac_pkg::PD_BITS-1:0]       power_down_mode_o,
  input logic                                 ready_res_o
);

  // The input side only stalls when a finished result is itself held back.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output register could drain");

  // A byte the device drives on a read is never acknowledged by the device.
  a_read_no_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (read_byte_o != '0)) |-> !acknowledge_o)
    else $error("read data byte carries a device acknowledge");

  // Once an accepted request has passed the input register, the output register holds a valid result.
  a_result_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> ##1 out_valid_o)
    else $error("accepted request produced no result in time");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(acknowledge_o)
      && $stable(read_byte_o) && $stable(output_code_o)
      && $stable(power_down_mode_o) && $stable(ready_res_o)))
    else $error("stalled result changed");

endmodule

bind i2c_dac_register_model_top i2cdac_chk u_i2cdac_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .acknowledge_o     (acknowledge_o),
  .read_byte_o       (read_byte_o),
  .output_code_o     (output_code_o),
  .power_down_mode_o (power_down_mode_o),
  .ready_res_o       (ready_res_o)
);

@@ tb/testbench.sv @@
module testbench;
  import i2cdac_pkg::*;

  // The watchdog gives up after this many cycles in which no request, no result and
  // no register write is accepted.
  localparam int unsigned STUCK_LIMIT = 2000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               cmd_i = CMD_TICK;
  logic [BYTE_BITS-1:0]     bus_byte_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     acknowledge_o;
  logic [BYTE_BITS-1:0]     read_byte_o;
  logic [CODE_BITS-1:0]     output_code_o;
  logic [PD_BITS-1:0]       power_down_mode_o;
  logic                     ready_res_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  i2c_dac_register_model_top DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .bus_byte_i        (bus_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .acknowledge_o     (acknowledge_o),
    .read_byte_o       (read_byte_o),
    .output_code_o     (output_code_o),
    .power_down_mode_o (power_down_mode_o),
    .ready_res_o       (ready_res_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // When set, neither side inserts idle cycles. The final phase runs this way.
  bit calm = 1'b0;

  // ---------------------------------------------------------------------------
  // Device shadow. It mirrors what the DAC should hold after every accepted bus
  // event, starting from the reset state, and is advanced in request order.
  // ---------------------------------------------------------------------------
  logic [PIN_BITS-1:0]  pins_now = '0;
  logic [BUSY_BITS-1:0] busy_ticks_now = BUSY_TICKS_RESET;
  logic [CODE_BITS-1:0] live_code = '0;
  logic [PD_BITS-1:0]   live_pd = '0;
  logic [CODE_BITS-1:0] nv_code = '0;
  logic [PD_BITS-1:0]   nv_pd = '0;
  logic [BUSY_BITS-1:0] busy_left = '0;
  logic [2:0]           frame_pos = '0;
  kind_e                frame_kind = K_IDLE;
  logic [BYTE_BITS-1:0] frame_held = '0;
  logic [PD_BITS-1:0]   frame_pd = '0;

  int unsigned events_sent = 0;
  int unsigned directed_sent = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned nv_commits = 0;
  int unsigned dropped_frames = 0;
  int unsigned mismatches = 0;

  // Every accepted request leaves exactly one reply here until the DUT returns it.
  result_t bus_replies_q[$];

  // A completed frame lands in the DAC (and optionally the EEPROM) unless an
  // EEPROM write is still in progress, in which case it is silently dropped.
  function automatic void commit_frame(logic [CODE_BITS-1:0] code, logic [PD_BITS-1:0] pd,
                                       bit to_nv);
    if (busy_left != '0) begin
      dropped_frames++;
      return;
    end
    live_code = code;
    live_pd   = pd;
    if (to_nv) begin
      nv_code   = code;
      nv_pd     = pd;
      busy_left = busy_ticks_now;
      nv_commits++;
    end
  endfunction

  function automatic result_t predict_bus_event(cmd_e cmd, logic [BYTE_BITS-1:0] b);
    result_t r;
    r = '0;
    case (cmd)
      CMD_START: begin
        frame_pos = '0;
        if (b[7:1] == {DEV_ADDR_HI, pins_now}) begin
          frame_kind    = b[0] ? K_READ : K_WRITE;
          r.acknowledge = 1'b1;
        end else if (b == GC_ADDR) begin
          frame_kind    = K_GCALL;
          r.acknowledge = 1'b1;
        end else begin
          frame_kind = K_IGNORE;
        end
      end
      CMD_DATA: begin
        case (frame_kind)
          // The master acknowledges read bytes, so the device never does here.
          K_READ: begin
            case (frame_pos)
              3'd0:    r.read_byte = {busy_left == '0, 1'b1, 3'b000, live_pd, 1'b0};
              3'd1:    r.read_byte = live_code[11:4];
              3'd2:    r.read_byte = {live_code[3:0], 4'h0};
              3'd3:    r.read_byte = {1'b0, nv_pd, 1'b0, nv_code[11:8]};
              default: r.read_byte = nv_code[7:0];
            endcase
            frame_pos = (frame_pos >= 3'd4) ? 3'd0 : frame_pos + 3'd1;
          end
          K_GCALL: begin
            if (b == GC_RESET) begin
              live_code     = nv_code;
              live_pd       = nv_pd;
              r.acknowledge = 1'b1;
            end else if (b == GC_WAKEUP) begin
              live_pd       = '0;
              r.acknowledge = 1'b1;
            end
          end
          K_WRITE: begin
            if (b[7:6] == 2'b00) begin
              frame_kind    = K_FAST;
              frame_held    = b;
              frame_pos     = 3'd1;
              r.acknowledge = 1'b1;
            end else if (b[7:6] == 2'b01) begin
              frame_kind    = b[5] ? K_REG_EE : K_REG_DAC;
              frame_pd      = b[2:1];
              frame_pos     = 3'd1;
              r.acknowledge = 1'b1;
            end else begin
              frame_kind = K_IGNORE;
            end
          end
          K_FAST: begin
            commit_frame({frame_held[3:0], b}, frame_held[5:4], 1'b0);
            frame_kind    = K_WRITE;
            frame_pos     = '0;
            r.acknowledge = 1'b1;
          end
          K_REG_DAC, K_REG_EE: begin
            if (frame_pos == 3'd1) begin
              frame_held = b;
              frame_pos  = 3'd2;
            end else begin
              commit_frame({frame_held, b[7:4]}, frame_pd, frame_kind == K_REG_EE);
              frame_kind = K_WRITE;
              frame_pos  = '0;
            end
            r.acknowledge = 1'b1;
          end
          default: ;
        endcase
      end
      CMD_STOP: begin
        frame_kind = K_IDLE;
        frame_pos  = '0;
      end
      default: begin
        if (busy_left != '0) busy_left = busy_left - 1'b1;
      end
    endcase
    r.output_code     = live_code;
    r.power_down_mode = live_pd;
    r.ready_res       = (busy_left == '0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------

  // Drives one bus event and waits until the DUT takes it. The reply for a row of
  // the directed script may be typed in by hand; the shadow is advanced either way.
  task automatic send_event(cmd_e cmd, logic [BYTE_BITS-1:0] b, bit typed = 1'b0,
                            result_t want = '0);
    result_t reply;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    bus_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    reply = predict_bus_event(cmd, b);
    bus_replies_q.push_back(typed ? want : reply);
    events_sent++;
  endtask

  // Registers are only touched with the pipeline drained. Both writes go out as one
  // burst so that the write valid stays high between them.
  task automatic reconfigure(logic [PIN_BITS-1:0] pins, logic [BUSY_BITS-1:0] ticks);
    in_valid_i <= 1'b0;
    while (bus_replies_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_ADDRESS_PINS;
    cfg_data_i  <= CFG_DATA_BITS'(pins);
    do @(posedge clk_i); while (!cfg_ready_o);
    pins_now    = pins;
    cfg_index_i <= CFG_BUSY_TICKS;
    cfg_data_i  <= ticks;
    do @(posedge clk_i); while (!cfg_ready_o);
    busy_ticks_now = ticks;
    cfg_valid_i <= 1'b0;
    reg_writes += 2;
  endtask

  // Mostly well-formed transfers with random content, plus tick bursts to let the
  // EEPROM timer run out, foreign addresses and some raw noise.
  task automatic bus_traffic(int unsigned quota);
    int unsigned first;
    int unsigned pick;
    int unsigned sel;
    int unsigned frames;
    logic [BYTE_BITS-1:0] b;
    bit cut;
    first = events_sent;
    while (events_sent - first < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // Write transfer: one to three frames, occasionally cut short.
        send_event(CMD_START, {DEV_ADDR_HI, pins_now, 1'b0});
        frames = $urandom_range(1, 3);
        cut    = 1'b0;
        for (int f = 0; f < frames && !cut; f++) begin
          b   = BYTE_BITS'($urandom);
          sel = $urandom_range(0, 9);
          if (sel < 4) b[7:6] = 2'b00;
          else if (sel < 9) b[7:6] = 2'b01;
          else b[7] = 1'b1;
          send_event(CMD_DATA, b);
          cut = ($urandom_range(0, 9) == 0);
          if (!cut) begin
            repeat ((b[7:6] == 2'b01) ? 2 : 1) send_event(CMD_DATA, BYTE_BITS'($urandom));
          end
        end
        if ($urandom_range(0, 7) != 0) send_event(CMD_STOP, BYTE_BITS'($urandom));
      end else if (pick < 55) begin
        // Read transfer long enough to wrap the five-byte readback now and then.
        send_event(CMD_START, {DEV_ADDR_HI, pins_now, 1'b1});
        repeat ($urandom_range(1, 7)) send_event(CMD_DATA, BYTE_BITS'($urandom));
        if ($urandom_range(0, 7) != 0) send_event(CMD_STOP, BYTE_BITS'($urandom));
      end else if (pick < 65) begin
        send_event(CMD_START, GC_ADDR);
        repeat ($urandom_range(1, 2)) begin
          sel = $urandom_range(0, 9);
          b   = (sel < 4) ? GC_RESET : (sel < 8) ? GC_WAKEUP : BYTE_BITS'($urandom);
          send_event(CMD_DATA, b);
        end
        send_event(CMD_STOP, BYTE_BITS'($urandom));
      end else if (pick < 75) begin
        // Some other address, or a general call with the read bit set.
        b = BYTE_BITS'($urandom);
        if ($urandom_range(0, 3) == 0) b = {GC_ADDR[7:1], 1'b1};
        send_event(CMD_START, b);
        repeat ($urandom_range(0, 2)) send_event(CMD_DATA, BYTE_BITS'($urandom));
        send_event(CMD_STOP, BYTE_BITS'($urandom));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 8)) send_event(CMD_TICK, BYTE_BITS'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_event(cmd_e'($urandom_range(0, 3)), BYTE_BITS'($urandom));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts and the in-order checker.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && !calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic note_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch %0d at reply %0d, %s: got 0x%0h, expected 0x%0h",
               mismatches, results_checked, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bus_replies_q.size() == 0) begin
        note_mismatch("reply with no request outstanding", output_code_o, 0);
      end else begin
        want = bus_replies_q.pop_front();
        if (acknowledge_o !== want.acknowledge)
          note_mismatch("acknowledge", acknowledge_o, want.acknowledge);
        if (read_byte_o !== want.read_byte)
          note_mismatch("read_byte", read_byte_o, want.read_byte);
        if (output_code_o !== want.output_code)
          note_mismatch("output_code", output_code_o, want.output_code);
        if (power_down_mode_o !== want.power_down_mode)
          note_mismatch("power_down_mode", power_down_mode_o, want.power_down_mode);
        if (ready_res_o !== want.ready_res)
          note_mismatch("ready_res", ready_res_o, want.ready_res);
      end
      results_checked++;
    end
  end

  // Watchdog: any accepted request, reply or register write counts as progress.
  int unsigned stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STUCK_LIMIT);
      $display("** i2c_dac_register_model_top: FAILED **");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed script. Rows with a typed reply are the ones that can be read off
  // by eye: the reset state, the first fast-mode write at full scale and the
  // bytes the device must refuse. The rest are checked against the shadow.
  // ---------------------------------------------------------------------------
  typedef struct {
    cmd_e                 cmd;
    logic [BYTE_BITS-1:0] data;
    bit                   typed;
    result_t              want;
  } bus_row_t;

  bus_row_t script_q[$];

  task automatic add_row(cmd_e cmd, logic [BYTE_BITS-1:0] data, bit typed = 1'b0,
                         result_t want = '0);
    bus_row_t row;
    row.cmd   = cmd;
    row.data  = data;
    row.typed = typed;
    row.want  = want;
    script_q.push_back(row);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A short EEPROM busy time keeps the directed part readable.
    reconfigure(3'd0, 16'd3);

    // Fields of a typed reply: acknowledge, read byte, code, power-down, ready.
    add_row(CMD_TICK,  8'h00, 1'b1, {1'b0, 8'h00, 12'h000, 2'd0, 1'b1});
    // A data byte with no open transfer is refused and changes nothing.
    add_row(CMD_DATA,  8'hFF, 1'b1, {1'b0, 8'h00, 12'h000, 2'd0, 1'b1});
    // Foreign address: refused, and the following byte is ignored as well.
    add_row(CMD_START, 8'hFF, 1'b1, {1'b0, 8'h00, 12'h000, 2'd0, 1'b1});
    add_row(CMD_DATA,  8'h12, 1'b1, {1'b0, 8'h00, 12'h000, 2'd0, 1'b1});
    // Fast-mode write of full scale with the deepest power-down.
    add_row(CMD_START, 8'hC0, 1'b1, {1'b1, 8'h00, 12'h000, 2'd0, 1'b1});
    add_row(CMD_DATA,  8'h3F, 1'b1, {1'b1, 8'h00, 12'h000, 2'd0, 1'b1});
    add_row(CMD_DATA,  8'hFF, 1'b1, {1'b1, 8'h00, 12'hFFF, 2'd3, 1'b1});
    // Reserved command byte: refused, rest of the transfer ignored.
    add_row(CMD_DATA,  8'h80, 1'b1, {1'b0, 8'h00, 12'hFFF, 2'd3, 1'b1});
    add_row(CMD_DATA,  8'h00, 1'b1, {1'b0, 8'h00, 12'hFFF, 2'd3, 1'b1});
    // Register mode with the EEPROM copy; the device goes busy afterwards.
    add_row(CMD_START, 8'hC0);
    add_row(CMD_DATA,  8'h62);
    add_row(CMD_DATA,  8'hAB);
    add_row(CMD_DATA,  8'hC0);
    // A fast-mode frame while busy is acknowledged but dropped.
    add_row(CMD_DATA,  8'h00);
    add_row(CMD_DATA,  8'h55);
    // A DAC-only register frame cut short by a stop.
    add_row(CMD_DATA,  8'h40);
    add_row(CMD_STOP,  8'h00);
    // Readback of all five bytes and the wrap to the status byte.
    add_row(CMD_START, 8'hC1);
    repeat (6) add_row(CMD_DATA, 8'h00);
    // General call: wake-up, reset from EEPROM, then an unknown command.
    add_row(CMD_START, GC_ADDR);
    add_row(CMD_DATA,  GC_WAKEUP);
    add_row(CMD_DATA,  GC_RESET);
    add_row(CMD_DATA,  8'h07);
    // General call with the read bit set is refused.
    add_row(CMD_START, {GC_ADDR[7:1], 1'b1});
    repeat (3) add_row(CMD_TICK, 8'hFF);

    foreach (script_q[i]) begin
      send_event(script_q[i].cmd, script_q[i].data, script_q[i].typed, script_q[i].want);
    end
    directed_sent = events_sent;

    // Highest address pins and the shortest busy time.
    reconfigure(3'd7, 16'd1);
    bus_traffic(350);

    // Long busy time: after the first EEPROM write every write is dropped for a
    // while, so the phase is short and the timer is then run down with ticks alone.
    reconfigure(3'($urandom_range(1, 6)), 16'd160);
    bus_traffic(150);
    calm = 1'b1;
    while (busy_left != '0) send_event(CMD_TICK, BYTE_BITS'($urandom));
    calm = 1'b0;

    reconfigure(3'($urandom_range(0, 7)), 16'($urandom_range(2, 24)));
    bus_traffic(450);

    // Final stretch at full rate on both sides.
    calm = 1'b1;
    reconfigure(3'd0, 16'($urandom_range(1, 12)));
    bus_traffic(450);

    in_valid_i <= 1'b0;
    while (bus_replies_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (bus_replies_q.size() != 0) begin
      note_mismatch("replies never returned", bus_replies_q.size(), 0);
    end

    $display("Sent %0d bus events (%0d scripted) over %0d register writes; %0d replies checked.",
             events_sent, directed_sent, reg_writes, results_checked);
    $display("EEPROM commits: %0d, frames dropped while busy: %0d, mismatches: %0d.",
             nv_commits, dropped_frames, mismatches);
    if (mismatches == 0) begin
      $display("** i2c_dac_register_model_top: PASSED **");
    end else begin
      $display("** i2c_dac_register_model_top: FAILED **");
    end
    $finish;
  end

endmodule
